[design/psev_pkg.sv]
// ----------------------------------------------------------------------------
// psev_pkg
// Shared types and constants for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package psev_pkg;

	localparam int DATA_W            = 32;
	localparam int STACK_DEPTH_DEF   = 128;

	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_ADD  = 8'd43;
	localparam logic [7:0] CH_SUB  = 8'd45;
	localparam logic [7:0] CH_MUL  = 8'd42;
	localparam logic [7:0] CH_DIV  = 8'd47;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_DIVZERO   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_expr;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		status_t                  status;
	} result_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

[design/postfix_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Postfix expression evaluator over a RAM-backed operand stack.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------
//   item     | item_valid / item_ready    | char_code, end_of_expr
//   result   | result_valid / result_ready| value, status
//
// Digit push: written on accept. + - *: stack read, then write back.
// /: as for + - * on a zero divisor, else via the 32-step divider.
// Last character: S_FINISH then loads the result register, held there
// while result_ready is low, and the next item waits until it is loaded.
// No clearing pass after reset: stack entries are only read below the count.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  psev_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output psev_pkg::result_t result
);

	localparam int W  = psev_pkg::DATA_W;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	psev_pkg::state_t  state_q;
	psev_pkg::state_t  state_d;
	psev_pkg::status_t sticky_q;
	psev_pkg::status_t fin_status;
	psev_pkg::result_t result_q;
	psev_pkg::div_ctl_t div_ctl;

	logic [CW-1:0] count_q;
	logic [W-1:0]  tos_q;
	logic [7:0]    op_q;
	logic          last_q;
	logic          result_valid_q;

	logic          item_fire;
	logic          is_op;
	logic          can_push;
	logic          short_stack;
	logic          out_free;
	logic [W-1:0]  push_val;
	logic [W-1:0]  alu_res;
	logic [W-1:0]  rd_data;
	logic [W-1:0]  div_q;
	logic [CW-1:0] second_idx;
	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_waddr;
	logic [W-1:0]  ram_wdata;
	logic          div_start;
	logic          wb;
	logic          div_zero;

	assign item_fire   = item_valid && item_ready;
	assign is_op       = (item.char_code == psev_pkg::CH_ADD) ||
	                     (item.char_code == psev_pkg::CH_SUB) ||
	                     (item.char_code == psev_pkg::CH_MUL) ||
	                     (item.char_code == psev_pkg::CH_DIV);
	assign can_push    = count_q < CW'(STACK_DEPTH);
	assign short_stack = count_q < CW'(2);
	assign out_free    = !result_valid_q || result_ready;
	assign push_val    = {{(W-8){1'b0}}, item.char_code} - W'(psev_pkg::CH_ZERO);
	assign second_idx  = count_q - CW'(2);
	assign div_zero    = (tos_q == '0);

	always_comb begin
		case (op_q)
			psev_pkg::CH_ADD: alu_res = rd_data + tos_q;
			psev_pkg::CH_SUB: alu_res = rd_data - tos_q;
			psev_pkg::CH_MUL: alu_res = rd_data * tos_q;
			default:          alu_res = (state_q == psev_pkg::S_DIV) ? div_q : '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			psev_pkg::S_IDLE: begin
				if (item_fire) begin
					if (is_op && !short_stack) begin
						state_d = psev_pkg::S_READ;
					end else if (item.end_of_expr) begin
						state_d = psev_pkg::S_FINISH;
					end
				end
			end
			psev_pkg::S_READ: begin
				if (op_q == psev_pkg::CH_DIV && !div_zero) begin
					state_d = psev_pkg::S_DIV;
				end else begin
					state_d = last_q ? psev_pkg::S_FINISH : psev_pkg::S_IDLE;
				end
			end
			psev_pkg::S_DIV: begin
				if (div_ctl.done) begin
					state_d = last_q ? psev_pkg::S_FINISH : psev_pkg::S_IDLE;
				end
			end
			psev_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = psev_pkg::S_IDLE;
				end
			end
			default: state_d = psev_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_ready = 1'b0;
		ram_re     = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = second_idx[AW-1:0];
		ram_wdata  = alu_res;
		div_start  = 1'b0;
		wb         = 1'b0;
		case (state_q)
			psev_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_fire && is_op && !short_stack) begin
					ram_re = 1'b1;
				end
				if (item_fire && !is_op && can_push) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[AW-1:0];
					ram_wdata = push_val;
				end
			end
			psev_pkg::S_READ: begin
				if (op_q == psev_pkg::CH_DIV && !div_zero) begin
					div_start = 1'b1;
				end else begin
					wb     = 1'b1;
					ram_we = 1'b1;
				end
			end
			psev_pkg::S_DIV: begin
				if (div_ctl.done) begin
					wb     = 1'b1;
					ram_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (sticky_q != psev_pkg::ST_OK) begin
			fin_status = sticky_q;
		end else if (count_q == '0) begin
			fin_status = psev_pkg::ST_UNDERFLOW;
		end else begin
			fin_status = psev_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= psev_pkg::S_IDLE;
			count_q        <= '0;
			sticky_q       <= psev_pkg::ST_OK;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				psev_pkg::S_IDLE: begin
					if (item_fire) begin
						if (is_op && short_stack) begin
							count_q <= '0;
							if (sticky_q == psev_pkg::ST_OK) begin
								sticky_q <= psev_pkg::ST_UNDERFLOW;
							end
						end else if (!is_op && can_push) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				psev_pkg::S_READ: begin
					if (op_q == psev_pkg::CH_DIV && div_zero &&
					    sticky_q == psev_pkg::ST_OK) begin
						sticky_q <= psev_pkg::ST_DIVZERO;
					end
				end
				psev_pkg::S_FINISH: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						count_q        <= '0;
						sticky_q       <= psev_pkg::ST_OK;
					end
				end
				default: begin
				end
			endcase
			if (wb) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			op_q   <= item.char_code;
			last_q <= item.end_of_expr;
			if (!is_op && can_push) begin
				tos_q <= push_val;
			end
		end
		if (wb) begin
			tos_q <= alu_res;
		end
		if (state_q == psev_pkg::S_FINISH && out_free) begin
			result_q.status <= fin_status;
			result_q.value  <= (fin_status == psev_pkg::ST_OK) ? tos_q : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	psev_ram #(
		.WIDTH(W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (second_idx[AW-1:0]),
		.rdata (rd_data)
	);

	psev_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_data),
		.divisor  (tos_q),
		.ctl      (div_ctl),
		.quotient (div_q)
	);

endmodule

[design/psev_ram.sv]
// ----------------------------------------------------------------------------
// psev_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psev_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/psev_div.sv]
// ----------------------------------------------------------------------------
// psev_div
// Radix-2 restoring signed divider, truncating toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
module psev_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [psev_pkg::DATA_W-1:0]   dividend,
	input  logic [psev_pkg::DATA_W-1:0]   divisor,
	output psev_pkg::div_ctl_t            ctl,
	output logic [psev_pkg::DATA_W-1:0]   quotient
);

	localparam int W  = psev_pkg::DATA_W;
	localparam int NW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dvs_q;
	logic          neg_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W+1:0]  trial;
	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;

	assign mag_a = dividend[W-1] ? (W'(0) - dividend) : dividend;
	assign mag_b = divisor[W-1]  ? (W'(0) - divisor)  : divisor;
	assign trial = {1'b0, rem_q, dvd_q[W-1]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			if (!trial[W+1]) begin
				rem_q <= trial[W-1:0];
				dvd_q <= {dvd_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], dvd_q[W-1]};
				dvd_q <= {dvd_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = neg_q ? (W'(0) - dvd_q) : dvd_q;
	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;

endmodule

[design/psev_chk.sv]
// ----------------------------------------------------------------------------
// psev_chk
// Port-level checks for the postfix stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module psev_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input psev_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input psev_pkg::result_t result
);

	logic item_is_op;

	assign item_is_op = (item.char_code == psev_pkg::CH_ADD) ||
	                    (item.char_code == psev_pkg::CH_SUB) ||
	                    (item.char_code == psev_pkg::CH_MUL) ||
	                    (item.char_code == psev_pkg::CH_DIV);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status == psev_pkg::ST_OK) ||
		                 (result.status == psev_pkg::ST_UNDERFLOW) ||
		                 (result.status == psev_pkg::ST_DIVZERO))
		else $error("illegal status");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != psev_pkg::ST_OK |-> result.value == '0)
		else $error("nonzero value with error status");

	a_push_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !item_is_op && !item.end_of_expr |=> item_ready)
		else $error("push did not complete in one cycle");

endmodule

bind postfix_stack_evaluator psev_chk u_psev_chk (.*);
